### rtl/hfov_pkg.sv
// Package for the horizontal field-of-view point filter.
// Holds widths, CORDIC constants, the arctangent table and the
// controller/datapath interface types. No dependencies.
package hfov_pkg;

	localparam int MAX_STEPS        = 24;
	localparam int STEP_W           = 5;
	localparam int DEF_CORDIC_STEPS = 16;
	localparam int DEF_ANGLE_BITS   = 16;

	localparam int QW    = 18;   // Q1.16 quaternion / heading
	localparam int CW    = 32;   // Q16.16 coordinate
	localparam int DW    = 33;   // coordinate difference
	localparam int PW    = 51;   // QW x DW product
	localparam int AW    = 54;   // accumulator and CORDIC x/y
	localparam int ZW    = 34;   // CORDIC angle, 2^31 = pi
	localparam int LIM_W = 16;
	localparam int IDX_W = 3;

	localparam int IN_DATA_W  = 184;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 112;

	localparam logic signed [ZW-1:0] ANG_PI      = 34'sd2147483648;
	localparam logic signed [ZW-1:0] ANG_HALF_PI = 34'sd1073741824;
	localparam logic signed [AW-1:0] GAIN_Q30    = 54'sd652032875;

	localparam logic [0:0] REG_LEFT  = 1'b0;
	localparam logic [0:0] REG_RIGHT = 1'b1;

	function automatic logic [31:0] atan_lut(input logic [STEP_W-1:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_CHECK  = 10'b0000000010,
		S_MAC    = 10'b0000000100,
		S_VLOAD  = 10'b0000001000,
		S_VEC    = 10'b0000010000,
		S_RLOAD  = 10'b0000100000,
		S_ROT    = 10'b0001000000,
		S_FIN    = 10'b0010000000,
		S_DECIDE = 10'b0100000000,
		S_EMIT   = 10'b1000000000
	} state_t;

	typedef struct packed {
		logic              capture;
		logic              clr_acc;
		logic              mac_mul;
		logic              mac_acc;
		logic [IDX_W-1:0]  mac_idx;
		logic              clear_pose;
		logic              vload;
		logic              rload;
		logic              step;
		logic              rot_mode;
		logic [STEP_W-1:0] step_idx;
		logic              fin;
		logic              decide;
		logic              emit;
	} cmd_t;

	typedef struct packed {
		logic is_point;
		logic quat_zero;
		logic point_go;
		logic last;
		logic keep;
		logic out_free;
	} status_t;

endpackage

### rtl/hfov_ctrl.sv
// Controller state machine of the field-of-view filter.
// Sequences multiply-accumulate, CORDIC vectoring/rotation and output.
// Depends on hfov_pkg.
module hfov_ctrl #(
	parameter int CORDIC_STEPS = hfov_pkg::DEF_CORDIC_STEPS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  hfov_pkg::status_t status,
	output hfov_pkg::cmd_t    cmd
);
	import hfov_pkg::*;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	logic [STEP_W-1:0] n_prod;

	assign n_prod   = status.is_point ? STEP_W'(4) : STEP_W'(6);
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.mac_idx  = cnt_q[IDX_W-1:0];
		cmd.step_idx = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.clr_acc = 1'b1;
				cnt_d       = '0;
				if (!status.is_point) begin
					if (status.quat_zero) begin
						cmd.clear_pose = 1'b1;
						state_d        = S_IDLE;
					end else begin
						state_d = S_MAC;
					end
				end else if (status.point_go) begin
					state_d = S_MAC;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_MAC: begin
				// product k is registered, then accumulated in the following cycle
				cmd.mac_mul = (cnt_q < n_prod);
				cmd.mac_acc = (cnt_q != '0);
				if (cnt_q == n_prod) begin
					cnt_d   = '0;
					state_d = S_VLOAD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_VLOAD: begin
				cmd.vload = 1'b1;
				cnt_d     = '0;
				state_d   = S_VEC;
			end
			S_VEC: begin
				cmd.step = 1'b1;
				if (cnt_q == LAST_STEP) begin
					cnt_d   = '0;
					state_d = status.is_point ? S_DECIDE : S_RLOAD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_RLOAD: begin
				cmd.rload = 1'b1;
				cnt_d     = '0;
				state_d   = S_ROT;
			end
			S_ROT: begin
				cmd.step     = 1'b1;
				cmd.rot_mode = 1'b1;
				if (cnt_q == LAST_STEP) begin
					cnt_d   = '0;
					state_d = S_FIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_IDLE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				if (status.keep || status.last) begin
					if (status.out_free) begin
						cmd.emit = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("result loaded while output register busy");
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == S_IDLE)
		else $error("controller not idle after result");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> cnt_q <= LAST_STEP)
		else $error("CORDIC step index out of range");

endmodule

### rtl/hfov_dp.sv
// Datapath of the field-of-view filter: input capture, pose state,
// multiply-accumulate, shared CORDIC, bearing check and output register.
// Depends on hfov_pkg.
module hfov_dp #(
	parameter int ANGLE_BITS = hfov_pkg::DEF_ANGLE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [hfov_pkg::IN_DATA_W-1:0]       in_data,
	input  logic [hfov_pkg::IN_USER_W-1:0]       in_user,
	input  logic                                 in_last,
	input  logic                                 cfg_we,
	input  logic [0:0]                           cfg_addr,
	input  logic [hfov_pkg::LIM_W-1:0]           cfg_wdata,
	input  hfov_pkg::cmd_t                       cmd,
	output hfov_pkg::status_t                    status,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [hfov_pkg::OUT_DATA_W-1:0]      out_data,
	output logic                                 out_user,
	output logic                                 out_last
);
	import hfov_pkg::*;

	localparam int BW = ANGLE_BITS + 2;

	function automatic logic signed [QW-1:0] q30_sat(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] r;
		r = (v + 54'sd8192) >>> 14;
		if (r > 54'sd65536)
			r = 54'sd65536;
		else if (r < -54'sd65536)
			r = -54'sd65536;
		return r[QW-1:0];
	endfunction

	// configuration and pose state
	logic [LIM_W-1:0]     left_q, right_q;
	logic signed [QW-1:0] cos_q, sin_q;
	logic signed [CW-1:0] rx_q, ry_q;
	logic                 pose_valid_q;

	// captured item
	logic                 kind_q, fin_q, last_q;
	logic signed [QW-1:0] qx_q, qy_q, qz_q, qw_q;
	logic signed [CW-1:0] cx_q, cy_q, cz_q;
	logic [15:0]          int_q;
	logic signed [DW-1:0] dx_q, dy_q;

	// multiply-accumulate
	logic signed [QW-1:0] op_a;
	logic signed [DW-1:0] op_b;
	logic                 op_tgt, op_neg;
	logic signed [PW-1:0] prod_s1;
	logic                 tgt_s1, neg_s1;
	logic signed [AW-1:0] acc_a_q, acc_b_q, prod_ext;

	// CORDIC
	logic signed [AW-1:0] xr_q, yr_q, xs, ys, x0, y0;
	logic signed [ZW-1:0] zr_q, at, zc;
	logic                 neg_q, dir_pos, hold;

	// bearing
	logic signed [ZW-1:0]     zrnd, zsh;
	logic signed [BW-1:0]     bear;
	logic [ANGLE_BITS+15:0]   lim_l_w, lim_r_w;
	logic [ANGLE_BITS-1:0]    lim_l, lim_r;
	logic                     inview, keep_q;

	logic [OUT_DATA_W-1:0] data_q;
	logic                  valid_q, user_q, olast_q;

	// ---- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= 16'd7220;
			right_q <= 16'd7187;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_LEFT:  left_q  <= cfg_wdata;
				REG_RIGHT: right_q <= cfg_wdata;
			endcase
		end
	end

	// ---- capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= in_user[0];
			fin_q  <= in_user[1];
			last_q <= in_last;
			qx_q   <= in_data[17:0];
			qy_q   <= in_data[35:18];
			qz_q   <= in_data[53:36];
			qw_q   <= in_data[71:54];
			cx_q   <= in_data[103:72];
			cy_q   <= in_data[135:104];
			cz_q   <= in_data[167:136];
			int_q  <= in_data[183:168];
			dx_q   <= {in_data[103], in_data[103:72]} - {rx_q[CW-1], rx_q};
			dy_q   <= {in_data[135], in_data[135:104]} - {ry_q[CW-1], ry_q};
		end
	end

	// ---- multiply-accumulate operand order
	// point: fwd = c*dx + s*dy (A), left = c*dy - s*dx (B)
	// pose:  xc = w*w + x*x - y*y - z*z (A), (w*z + x*y) (B, doubled later)
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_tgt = 1'b0;
		op_neg = 1'b0;
		if (kind_q) begin
			unique case (cmd.mac_idx)
				3'd0: begin op_a = cos_q; op_b = dx_q; end
				3'd1: begin op_a = sin_q; op_b = dy_q; end
				3'd2: begin op_a = cos_q; op_b = dy_q; op_tgt = 1'b1; end
				3'd3: begin op_a = sin_q; op_b = dx_q; op_tgt = 1'b1; op_neg = 1'b1; end
				default: ;
			endcase
		end else begin
			unique case (cmd.mac_idx)
				3'd0: begin op_a = qw_q; op_b = DW'(qw_q); end
				3'd1: begin op_a = qx_q; op_b = DW'(qx_q); end
				3'd2: begin op_a = qy_q; op_b = DW'(qy_q); op_neg = 1'b1; end
				3'd3: begin op_a = qz_q; op_b = DW'(qz_q); op_neg = 1'b1; end
				3'd4: begin op_a = qw_q; op_b = DW'(qz_q); op_tgt = 1'b1; end
				3'd5: begin op_a = qx_q; op_b = DW'(qy_q); op_tgt = 1'b1; end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_mul) begin
			prod_s1 <= op_a * op_b;
			tgt_s1  <= op_tgt;
			neg_s1  <= op_neg;
		end
	end

	assign prod_ext = {{(AW-PW){prod_s1[PW-1]}}, prod_s1};

	always_ff @(posedge clk) begin
		if (cmd.clr_acc) begin
			acc_a_q <= '0;
			acc_b_q <= '0;
		end else if (cmd.mac_acc) begin
			if (tgt_s1)
				acc_b_q <= neg_s1 ? acc_b_q - prod_ext : acc_b_q + prod_ext;
			else
				acc_a_q <= neg_s1 ? acc_a_q - prod_ext : acc_a_q + prod_ext;
		end
	end

	// ---- CORDIC, one micro-rotation per cycle while stepping (none once y is zero in vectoring)
	assign x0      = acc_a_q;
	assign y0      = kind_q ? acc_b_q : (acc_b_q <<< 1);
	assign xs      = xr_q >>> cmd.step_idx;
	assign ys      = yr_q >>> cmd.step_idx;
	assign at      = ZW'(atan_lut(cmd.step_idx));
	assign dir_pos = cmd.rot_mode ? !zr_q[ZW-1] : yr_q[AW-1];
	assign hold    = !cmd.rot_mode && (yr_q == '0);

	always_comb begin
		if (zr_q > ANG_PI)
			zc = ANG_PI;
		else if (zr_q < -ANG_PI)
			zc = -ANG_PI;
		else
			zc = zr_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.vload) begin
			// fold the left half-plane onto the right one
			if (x0[AW-1]) begin
				if (!y0[AW-1]) begin
					xr_q <= y0;
					yr_q <= -x0;
					zr_q <= ANG_HALF_PI;
				end else begin
					xr_q <= -y0;
					yr_q <= x0;
					zr_q <= -ANG_HALF_PI;
				end
			end else begin
				xr_q <= x0;
				yr_q <= y0;
				zr_q <= '0;
			end
		end else if (cmd.rload) begin
			xr_q <= GAIN_Q30;
			yr_q <= '0;
			if (zc > ANG_HALF_PI) begin
				zr_q  <= zc - ANG_PI;
				neg_q <= 1'b1;
			end else if (zc < -ANG_HALF_PI) begin
				zr_q  <= zc + ANG_PI;
				neg_q <= 1'b1;
			end else begin
				zr_q  <= zc;
				neg_q <= 1'b0;
			end
		end else if (cmd.step && !hold) begin
			if (dir_pos) begin
				xr_q <= xr_q - ys;
				yr_q <= yr_q + xs;
				zr_q <= zr_q - at;
			end else begin
				xr_q <= xr_q + ys;
				yr_q <= yr_q - xs;
				zr_q <= zr_q + at;
			end
		end
	end

	// ---- pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q        <= '0;
			sin_q        <= '0;
			rx_q         <= '0;
			ry_q         <= '0;
			pose_valid_q <= 1'b0;
		end else if (cmd.clear_pose) begin
			pose_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			cos_q        <= q30_sat(neg_q ? -xr_q : xr_q);
			sin_q        <= q30_sat(neg_q ? -yr_q : yr_q);
			rx_q         <= cx_q;
			ry_q         <= cy_q;
			pose_valid_q <= 1'b1;
		end
	end

	// ---- bearing against the limits
	assign zrnd    = zc + (34'sd1 <<< (31 - ANGLE_BITS));
	assign zsh     = zrnd >>> (32 - ANGLE_BITS);
	assign bear    = zsh[BW-1:0];
	assign lim_l_w = {left_q, {ANGLE_BITS{1'b0}}};
	assign lim_r_w = {right_q, {ANGLE_BITS{1'b0}}};
	assign lim_l   = lim_l_w[ANGLE_BITS+15:16];
	assign lim_r   = lim_r_w[ANGLE_BITS+15:16];
	assign inview  = (bear >= -$signed({2'b00, lim_r})) && (bear <= $signed({2'b00, lim_l}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			keep_q <= 1'b0;
		else if (cmd.capture)
			keep_q <= 1'b0;
		else if (cmd.decide)
			keep_q <= inview;
	end

	// ---- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			data_q  <= keep_q ? {int_q, cz_q, cy_q, cx_q} : '0;
			user_q  <= keep_q;
			olast_q <= last_q;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_user  = user_q;
	assign out_last  = olast_q;

	assign status.is_point  = kind_q;
	assign status.quat_zero = (qx_q == '0) && (qy_q == '0) && (qz_q == '0) && (qw_q == '0);
	assign status.point_go  = pose_valid_q && fin_q;
	assign status.last      = last_q;
	assign status.keep      = keep_q;
	assign status.out_free  = !valid_q || out_ready;

endmodule

### rtl/horizontal_fov_point_filter_unit.sv
// Horizontal field-of-view sector filter for a point stream.
// Input stream carries pose updates and points; output stream carries kept
// points and end-of-cloud markers. Two limit registers on a write port.
//
// A pose transfer (tuser[0] = 0) sets the heading from the yaw of its
// quaternion and the robot position; a zero quaternion invalidates the pose.
// A point transfer (tuser[0] = 1) is shifted to the robot, turned into the
// heading frame and its bearing found by CORDIC vectoring; it is passed on
// when -right_limit <= bearing <= left_limit. A dropped last point still
// gives a marker with tuser = 0 and tlast = 1; other dropped points vanish.
// A point's result is loaded into the output register after the check,
// MAC, vectoring and decide states, or right after the check for a point
// dropped for lack of a valid pose or finite flag; s_axis_tready returns
// in that same cycle. A pose holds the input through the check, MAC,
// vectoring, rotation and finish states, a zero-quaternion pose only
// through the check. One item is processed at a time on the shared CORDIC.
// The result sits in an output register: a stalled receiver holds the
// finished result there and the next item may be accepted meanwhile.
// Reset clears the pose (points are dropped until a valid pose arrives)
// and restores the default limits.
module horizontal_fov_point_filter_unit #(
	parameter int CORDIC_STEPS = hfov_pkg::DEF_CORDIC_STEPS,
	parameter int ANGLE_BITS   = hfov_pkg::DEF_ANGLE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// quat_x, quat_y, quat_z, quat_w, coord_x, coord_y, coord_z, intensity
	input  logic [hfov_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// kind, point_finite
	input  logic [hfov_pkg::IN_USER_W-1:0]    s_axis_tuser,
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// out_x, out_y, out_z, out_intensity
	output logic [hfov_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// kept
	output logic                              m_axis_tuser,
	output logic                              m_axis_tlast,
	input  logic                              cfg_we,
	input  logic [0:0]                        cfg_addr,
	input  logic [hfov_pkg::LIM_W-1:0]        cfg_wdata
);
	import hfov_pkg::*;

	cmd_t    cmd;
	status_t status;

	hfov_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	hfov_dp #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.in_last   (s_axis_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule
